>>> rtl/core/fba_pkg.sv
// Shared types and constants for the fragment bitmap allocator.
// Used by the top level and the port checker; no dependencies.
package fba_pkg;

   localparam int KIND_W = 2;
   localparam int POS_W = 10;
   localparam int COUNT_W = 4;
   localparam int START_W = 10;
   localparam int SCORE_W = 11;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   // map size is tied to the position and score field widths
   localparam int MAP_BITS = 1024;

   typedef enum logic [KIND_W-1:0] {
      KIND_SMALL = 2'd0,
      KIND_ALIGN = 2'd1,
      KIND_MARK = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRIME,
      ST_SCAN_SMALL,
      ST_SCAN_ALIGN,
      ST_MARK_SEEK,
      ST_MARK_WRITE,
      ST_REPLY
   } state_type;

endpackage

>>> rtl/core/fba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module fba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/fragment_bitmap_allocator_top.sv
// Fragment bitmap allocator top level: sequencer, scoring unit and row store.
// Depends on fba_pkg and fba_ram.
//
// The used/free map is held as rows of one block window each (MAP_BITS /
// FRAGS_PER_BLOCK rows, rounded up) in a single-port-read RAM; per-row valid flops make
// the map read as all free right after reset, so no clearing pass is needed.
// One item is worked on at a time and req_tready is low while it runs. The
// RAM read port delivers one row per cycle and sets the pace: an aligned
// search reads the rows until it finds a place or reaches the last full row;
// a best-fit search reads the rows in turn and stops again on each used
// fragment it meets, and on the map end, until it finds an exact fit or the
// map ends; mark and clear walk the rows up to the target row. A finished
// result waits in an output register, and the next item can be taken while
// it waits.
module fragment_bitmap_allocator_top #(
   parameter int FRAGS_PER_BLOCK = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [fba_pkg::REQ_DATA_W-1:0]   req_tdata,  // position[9:0], count[13:10]
   input  logic [fba_pkg::KIND_W-1:0]       req_tuser,  // kind[1:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [fba_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // start_res[9:0], score[20:10]
   output logic                             rsp_tuser   // found[0]
);

   localparam int MAP_BITS = fba_pkg::MAP_BITS;
   localparam int W = FRAGS_PER_BLOCK;
   localparam int NROWS = (MAP_BITS + W - 1) / W;
   localparam int FULL_ROWS = MAP_BITS / W;
   localparam int END_ROW = MAP_BITS / W;
   localparam int END_OFF = MAP_BITS % W;
   localparam int AW = (NROWS > 1) ? $clog2(NROWS) : 1;
   localparam int RW = $clog2(NROWS + 2);
   localparam int OW = $clog2(W);
   localparam int LW = $clog2(MAP_BITS + W + 1);

   fba_pkg::state_type state_ff, state_in;
   fba_pkg::kind_type kind_ff, kind_in;
   logic [fba_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [fba_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [RW-1:0] row_ff, row_in;
   logic [LW-1:0] base_ff, base_in;
   logic [OW-1:0] off_ff, off_in;
   logic [LW-1:0] last_lin_ff, last_lin_in;
   logic [RW-1:0] last_row_ff, last_row_in;
   logic [OW-1:0] last_off_ff, last_off_in;
   logic [LW-1:0] last_base_ff, last_base_in;
   logic res_found_ff, res_found_in;
   logic [LW-1:0] res_start_ff, res_start_in;
   logic [LW-1:0] res_score_ff, res_score_in;
   logic [NROWS-1:0] valid_ff, valid_in;
   logic rd_valid_ff, rd_valid_in;
   logic rsp_tvalid_ff, rsp_tvalid_in;
   logic rsp_found_ff, rsp_found_in;
   logic [fba_pkg::START_W-1:0] rsp_start_ff, rsp_start_in;
   logic [fba_pkg::SCORE_W-1:0] rsp_score_ff, rsp_score_in;

   logic ram_we;
   logic [W-1:0] ram_wdata, ram_rdata;
   logic [AW-1:0] ram_raddr;

   // scan datapath
   logic [W-1:0] row_data, hit, free_bits, size_mask, ok;
   logic any_hit, any_ok;
   logic [OW-1:0] hit_off, ok_off, ev_off;
   logic [LW-1:0] i_lin, run, size_l, cand_score, cand_place, ev_best;
   logic take;
   logic req_beat;

   fba_ram #(
      .WIDTH(W),
      .DEPTH(NROWS)
   ) u_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(row_ff[AW-1:0]),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign req_tready = (state_ff == fba_pkg::ST_IDLE);
   assign req_beat = req_tvalid && req_tready;

   // address the row the scan will look at next cycle
   assign ram_raddr = row_in[AW-1:0];
   assign rd_valid_in = (row_in < RW'(NROWS)) && valid_ff[row_in[AW-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fba_pkg::ST_IDLE;
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         rd_valid_ff <= rd_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      pos_ff <= pos_in;
      count_ff <= count_in;
      row_ff <= row_in;
      base_ff <= base_in;
      off_ff <= off_in;
      last_lin_ff <= last_lin_in;
      last_row_ff <= last_row_in;
      last_off_ff <= last_off_in;
      last_base_ff <= last_base_in;
      res_found_ff <= res_found_in;
      res_start_ff <= res_start_in;
      res_score_ff <= res_score_in;
      rsp_found_ff <= rsp_found_in;
      rsp_start_ff <= rsp_start_in;
      rsp_score_ff <= rsp_score_in;
   end

   // row search: first used fragment at or after the current offset,
   // and first aligned free run of count fragments
   always_comb begin
      row_data = rd_valid_ff ? ram_rdata : '0;
      free_bits = ~row_data;
      for (int b = 0; b < W; b++) begin
         hit[b] = row_data[b] && (OW'(b) >= off_ff);
         size_mask[b] = (b < int'(count_ff));
      end
      for (int j = 0; j < W; j++) begin
         ok[j] = ((free_bits >> j) & size_mask) == size_mask;
      end
      any_hit = |hit;
      any_ok = |ok;
      hit_off = '0;
      ok_off = '0;
      for (int b = W - 1; b >= 0; b--) begin
         if (hit[b]) begin
            hit_off = OW'(b);
         end
         if (ok[b]) begin
            ok_off = OW'(b);
         end
      end
   end

   // best-fit scoring of the free run closed at (row_ff, ev_off)
   always_comb begin
      ev_off = any_hit ? hit_off : OW'(END_OFF);
      i_lin = base_ff + LW'(ev_off);
      run = i_lin - last_lin_ff;
      size_l = LW'(count_ff);
      take = 1'b0;
      cand_score = res_score_ff;
      cand_place = res_start_ff;
      if (run >= size_l) begin
         if (row_ff == last_row_ff) begin
            cand_score = run;
            cand_place = last_lin_ff;
            take = (run < res_score_ff);
         end else if (LW'(last_off_ff) + size_l <= LW'(W)) begin
            cand_score = LW'(W) - LW'(last_off_ff);
            cand_place = last_lin_ff;
            take = (cand_score < res_score_ff);
         end else if (LW'(ev_off) >= size_l) begin
            cand_score = LW'(ev_off);
            cand_place = base_ff;
            take = (cand_score < res_score_ff);
         end else if ((RW + 1)'(row_ff) > (RW + 1)'(last_row_ff) + 1'b1) begin
            // whole window inside the run: taken regardless of the kept score
            cand_score = LW'(W);
            cand_place = last_base_ff + LW'(W);
            take = 1'b1;
         end
      end
      ev_best = take ? cand_score : res_score_ff;
   end

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      pos_in = pos_ff;
      count_in = count_ff;
      row_in = row_ff;
      base_in = base_ff;
      off_in = off_ff;
      last_lin_in = last_lin_ff;
      last_row_in = last_row_ff;
      last_off_in = last_off_ff;
      last_base_in = last_base_ff;
      res_found_in = res_found_ff;
      res_start_in = res_start_ff;
      res_score_in = res_score_ff;
      valid_in = valid_ff;
      ram_we = 1'b0;
      ram_wdata = row_data;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_start_in = rsp_start_ff;
      rsp_score_in = rsp_score_ff;

      unique case (state_ff)
         fba_pkg::ST_IDLE: begin
            if (req_beat) begin
               kind_in = fba_pkg::kind_type'(req_tuser);
               pos_in = req_tdata[fba_pkg::POS_W-1:0];
               count_in = req_tdata[fba_pkg::POS_W +: fba_pkg::COUNT_W];
               row_in = '0;
               base_in = '0;
               off_in = '0;
               last_lin_in = '0;
               last_row_in = '0;
               last_off_in = '0;
               last_base_in = '0;
               res_start_in = '0;
               res_score_in = '0;
               res_found_in = 1'b0;
               case (fba_pkg::kind_type'(req_tuser))
                  fba_pkg::KIND_SMALL: begin
                     res_score_in = LW'(MAP_BITS);
                     state_in = fba_pkg::ST_PRIME;
                  end
                  fba_pkg::KIND_ALIGN: begin
                     state_in = fba_pkg::ST_PRIME;
                  end
                  default: begin
                     res_found_in = 1'b1;
                     if (int'(req_tdata[fba_pkg::POS_W-1:0]) < MAP_BITS) begin
                        state_in = fba_pkg::ST_MARK_SEEK;
                     end else begin
                        state_in = fba_pkg::ST_REPLY;
                     end
                  end
               endcase
            end
         end
         fba_pkg::ST_PRIME: begin
            // row 0 is being read this cycle
            if (kind_ff == fba_pkg::KIND_SMALL) begin
               state_in = fba_pkg::ST_SCAN_SMALL;
            end else if (count_ff == '0 || int'(count_ff) > W || FULL_ROWS == 0) begin
               state_in = fba_pkg::ST_REPLY;
            end else begin
               state_in = fba_pkg::ST_SCAN_ALIGN;
            end
         end
         fba_pkg::ST_SCAN_SMALL: begin
            if (any_hit || row_ff == RW'(END_ROW)) begin
               if (take) begin
                  res_score_in = cand_score;
                  res_start_in = cand_place;
                  res_found_in = 1'b1;
               end
               if (ev_best == size_l || !any_hit) begin
                  state_in = fba_pkg::ST_REPLY;
               end else begin
                  last_lin_in = i_lin + 1'b1;
                  if (ev_off == OW'(W - 1)) begin
                     row_in = row_ff + 1'b1;
                     base_in = base_ff + LW'(W);
                     off_in = '0;
                     last_row_in = row_ff + 1'b1;
                     last_off_in = '0;
                     last_base_in = base_ff + LW'(W);
                  end else begin
                     off_in = ev_off + 1'b1;
                     last_row_in = row_ff;
                     last_off_in = ev_off + 1'b1;
                     last_base_in = base_ff;
                  end
               end
            end else begin
               row_in = row_ff + 1'b1;
               base_in = base_ff + LW'(W);
               off_in = '0;
            end
         end
         fba_pkg::ST_SCAN_ALIGN: begin
            if (any_ok) begin
               res_found_in = 1'b1;
               res_start_in = base_ff + LW'(ok_off);
               res_score_in = size_l;
               state_in = fba_pkg::ST_REPLY;
            end else if ((RW + 1)'(row_ff) + 1'b1 >= (RW + 1)'(FULL_ROWS)) begin
               state_in = fba_pkg::ST_REPLY;
            end else begin
               row_in = row_ff + 1'b1;
               base_in = base_ff + LW'(W);
            end
         end
         fba_pkg::ST_MARK_SEEK: begin
            if (LW'(pos_ff) < base_ff + LW'(W)) begin
               off_in = OW'(LW'(pos_ff) - base_ff);
               state_in = fba_pkg::ST_MARK_WRITE;
            end else begin
               row_in = row_ff + 1'b1;
               base_in = base_ff + LW'(W);
            end
         end
         fba_pkg::ST_MARK_WRITE: begin
            ram_we = 1'b1;
            ram_wdata[off_ff] = (kind_ff == fba_pkg::KIND_MARK);
            valid_in[row_ff[AW-1:0]] = 1'b1;
            state_in = fba_pkg::ST_REPLY;
         end
         fba_pkg::ST_REPLY: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_start_in = res_found_ff ? fba_pkg::START_W'(res_start_ff) : '0;
               rsp_score_in = fba_pkg::SCORE_W'(res_score_ff);
               state_in = fba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fba_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser = rsp_found_ff;
   assign rsp_tdata = {
      (fba_pkg::RSP_DATA_W - fba_pkg::START_W - fba_pkg::SCORE_W)'(0),
      rsp_score_ff,
      rsp_start_ff
   };

endmodule

>>> rtl/core/fba_checker.sv
// Port-level checker for the fragment bitmap allocator, bound to the top.
// Depends on fba_pkg.
module fba_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [fba_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // an accepted item keeps the block busy for at least the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready right after an accepted beat");

   // nothing found means start is zero
   a_miss_start_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[fba_pkg::START_W-1:0] == '0)
      else $error("start nonzero on a miss");

endmodule

bind fragment_bitmap_allocator_top fba_checker u_fba_checker (.*);

>>> dv/testbench.sv
// Self-checking bench for fragment_bitmap_allocator_top: a table of directed beats, then
// random mark/clear/search traffic, checked against fixed answers or an in-bench bitmap predictor.
// Depends on fba_pkg and the allocator RTL; needs no files or arguments.
module testbench;

   localparam int MAP_BITS = fba_pkg::MAP_BITS;
   localparam int FRAGS = 8;
   localparam int ITEMS = 1000;
   localparam int DRAIN_CYCLES = 1200;

   typedef struct packed {
      logic        found;
      logic [9:0]  start;
      logic [10:0] score;
   } alloc_result_type;

   typedef struct {
      fba_pkg::kind_type kind;
      logic [9:0]        pos;
      logic [3:0]        cnt;
      bit                typed;
      alloc_result_type  known;
   } dir_row_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [fba_pkg::REQ_DATA_W-1:0]   req_tdata = '0;   // position[9:0], count[13:10]
   logic [fba_pkg::KIND_W-1:0]       req_tuser = fba_pkg::KIND_SMALL;   // kind[1:0]
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [fba_pkg::RSP_DATA_W-1:0]   rsp_tdata;   // start_res[9:0], score[20:10]
   logic                             rsp_tuser;   // found[0]

   bit               used_map [MAP_BITS];
   alloc_result_type answers_due [$];
   bit               steady = 1'b0;
   int               errors = 0;
   int               n_sent = 0;
   int               n_checked = 0;
   int               n_small = 0;
   int               n_align = 0;
   int               n_mark = 0;
   int               n_clear = 0;
   int               n_no_place = 0;

   // Directed rows; typed answers are the obvious ones, the rest go to the predictor.
   dir_row_type directed_rows [25] = '{
      '{fba_pkg::KIND_SMALL, 10'd0,    4'd1,  1'b1, '{1'b1, 10'd0, 11'd8}},
      '{fba_pkg::KIND_SMALL, 10'd1023, 4'd8,  1'b1, '{1'b1, 10'd0, 11'd8}},
      '{fba_pkg::KIND_SMALL, 10'd0,    4'd0,  1'b1, '{1'b1, 10'd0, 11'd8}},
      '{fba_pkg::KIND_SMALL, 10'd0,    4'd15, 1'b1, '{1'b1, 10'd8, 11'd8}},
      '{fba_pkg::KIND_ALIGN, 10'd0,    4'd1,  1'b1, '{1'b1, 10'd0, 11'd1}},
      '{fba_pkg::KIND_ALIGN, 10'd1023, 4'd8,  1'b1, '{1'b1, 10'd0, 11'd8}},
      '{fba_pkg::KIND_ALIGN, 10'd0,    4'd0,  1'b1, '{1'b0, 10'd0, 11'd0}},
      '{fba_pkg::KIND_ALIGN, 10'd0,    4'd15, 1'b1, '{1'b0, 10'd0, 11'd0}},
      '{fba_pkg::KIND_MARK,  10'd0,    4'd15, 1'b1, '{1'b1, 10'd0, 11'd0}},
      '{fba_pkg::KIND_MARK,  10'd1023, 4'd0,  1'b1, '{1'b1, 10'd0, 11'd0}},
      '{fba_pkg::KIND_MARK,  10'd3,    4'd0,  1'b1, '{1'b1, 10'd0, 11'd0}},
      // empty run next to a used fragment is an exact fit for a zero count
      '{fba_pkg::KIND_SMALL, 10'd0,    4'd0,  1'b0, '{1'b0, 10'd0, 11'd0}},
      '{fba_pkg::KIND_SMALL, 10'd0,    4'd2,  1'b0, '{1'b0, 10'd0, 11'd0}},
      '{fba_pkg::KIND_SMALL, 10'd0,    4'd3,  1'b0, '{1'b0, 10'd0, 11'd0}},
      '{fba_pkg::KIND_ALIGN, 10'd0,    4'd8,  1'b0, '{1'b0, 10'd0, 11'd0}},
      '{fba_pkg::KIND_MARK,  10'd5,    4'd0,  1'b1, '{1'b1, 10'd0, 11'd0}},
      '{fba_pkg::KIND_SMALL, 10'd0,    4'd4,  1'b0, '{1'b0, 10'd0, 11'd0}},
      '{fba_pkg::KIND_MARK,  10'd1017, 4'd0,  1'b1, '{1'b1, 10'd0, 11'd0}},
      '{fba_pkg::KIND_SMALL, 10'd0,    4'd4,  1'b0, '{1'b0, 10'd0, 11'd0}},
      '{fba_pkg::KIND_ALIGN, 10'd0,    4'd4,  1'b0, '{1'b0, 10'd0, 11'd0}},
      '{fba_pkg::KIND_CLEAR, 10'd0,    4'd0,  1'b1, '{1'b1, 10'd0, 11'd0}},
      '{fba_pkg::KIND_CLEAR, 10'd1023, 4'd15, 1'b1, '{1'b1, 10'd0, 11'd0}},
      '{fba_pkg::KIND_CLEAR, 10'd3,    4'd0,  1'b1, '{1'b1, 10'd0, 11'd0}},
      '{fba_pkg::KIND_CLEAR, 10'd5,    4'd0,  1'b1, '{1'b1, 10'd0, 11'd0}},
      '{fba_pkg::KIND_CLEAR, 10'd1017, 4'd0,  1'b1, '{1'b1, 10'd0, 11'd0}}
   };

   fragment_bitmap_allocator_top #(
      .FRAGS_PER_BLOCK(FRAGS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #10 clock = ~clock;

   // Best-fit walk over free runs; each used fragment (or map end) closes a run.
   function automatic void best_fit_scan(input int want, output int place, output int best);
      int last;
      last = 0;
      best = MAP_BITS;
      place = -1;
      for (int i = 0; i <= MAP_BITS; i++) begin
         if (i != MAP_BITS && !used_map[i]) continue;
         if (i - last >= want) begin
            if (i / FRAGS == last / FRAGS) begin
               if (i - last < best) begin
                  best = i - last;
                  place = last;
               end
            end else if (last % FRAGS <= FRAGS - want) begin
               if (FRAGS - last % FRAGS < best) begin
                  best = FRAGS - last % FRAGS;
                  place = last;
               end
            end else if (i % FRAGS >= want) begin
               if (i % FRAGS < best) begin
                  best = i % FRAGS;
                  place = (i / FRAGS) * FRAGS;
               end
            end else if (i / FRAGS - last / FRAGS > 1) begin
               // whole window inside the run replaces the best unconditionally
               best = FRAGS;
               place = (last / FRAGS + 1) * FRAGS;
            end
         end
         if (best == want) break;
         last = i + 1;
      end
   endfunction

   function automatic int aligned_scan(input int want);
      bit clear_run;
      if (want <= 0) return -1;
      for (int base = 0; base + FRAGS <= MAP_BITS; base += FRAGS) begin
         for (int j = base; j + want <= base + FRAGS; j++) begin
            clear_run = 1'b1;
            for (int k = 0; k < want; k++)
               if (used_map[j + k]) clear_run = 1'b0;
            if (clear_run) return j;
         end
      end
      return -1;
   endfunction

   // Works out the answer for one accepted request and applies mark/clear to the map.
   function automatic alloc_result_type allocate_answer(input fba_pkg::kind_type kind,
                                                        input logic [9:0] pos,
                                                        input logic [3:0] cnt);
      alloc_result_type r;
      int place;
      int best;
      r = '0;
      r.found = 1'b1;
      case (kind)
         fba_pkg::KIND_SMALL: begin
            best_fit_scan(int'(cnt), place, best);
            n_small++;
            r.found = (place >= 0);
            r.start = (place >= 0) ? 10'(place) : 10'd0;
            r.score = 11'(best);
         end
         fba_pkg::KIND_ALIGN: begin
            place = aligned_scan(int'(cnt));
            n_align++;
            if (place >= 0) begin
               r.start = 10'(place);
               r.score = 11'(cnt);
            end else begin
               r.found = 1'b0;
            end
         end
         fba_pkg::KIND_MARK: begin
            used_map[pos] = 1'b1;
            n_mark++;
         end
         default: begin
            used_map[pos] = 1'b0;
            n_clear++;
         end
      endcase
      if (!r.found) n_no_place++;
      return r;
   endfunction

   task automatic issue_request(input fba_pkg::kind_type kind, input logic [9:0] pos,
                                input logic [3:0] cnt, input bit typed = 1'b0,
                                input alloc_result_type known = '0);
      alloc_result_type predicted;
      if (!steady && $urandom_range(0, 99) < 30) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 30);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {2'b00, cnt, pos};
      do @(posedge clock); while (!req_tready);
      predicted = allocate_answer(kind, pos, cnt);
      answers_due.push_back(typed ? known : predicted);
      n_sent++;
   endtask

   // Hold off the sender until every outstanding answer has been returned.
   task automatic drain_answers();
      req_tvalid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 30);
   end

   always @(posedge clock) begin
      alloc_result_type got;
      alloc_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tuser, rsp_tdata[9:0], rsp_tdata[20:10]};
         n_checked++;
         if (answers_due.size() == 0) begin
            $error("result beat with no answer outstanding");
            errors++;
         end else begin
            want = answers_due.pop_front();
            if (got.found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, got.found);
               errors++;
            end
            if (got.start !== want.start) begin
               $error("start_res: expected %0d, got %0d", want.start, got.start);
               errors++;
            end
            if (got.score !== want.score) begin
               $error("score: expected %0d, got %0d", want.score, got.score);
               errors++;
            end
         end
      end
   end

   initial begin
      bit pattern_done;
      int choice;
      int hot;
      int nops;
      logic [3:0] cnt;
      pattern_done = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         issue_request(directed_rows[r].kind, directed_rows[r].pos, directed_rows[r].cnt,
                       directed_rows[r].typed, directed_rows[r].known);

      while (n_sent < ITEMS) begin
         steady = (n_sent >= 600 && n_sent < 750);
         if (!pattern_done && n_sent >= 400) begin
            // one used fragment per window: no run reaches a full window anywhere
            pattern_done = 1'b1;
            for (int w = 0; w < MAP_BITS; w += FRAGS)
               issue_request(fba_pkg::KIND_MARK, 10'(w + 3), 4'($urandom));
            drain_answers();
            issue_request(fba_pkg::KIND_SMALL, 10'($urandom), 4'd8);
            issue_request(fba_pkg::KIND_SMALL, 10'($urandom), 4'd9);
            issue_request(fba_pkg::KIND_SMALL, 10'($urandom), 4'd15);
            issue_request(fba_pkg::KIND_ALIGN, 10'($urandom), 4'd5);
            issue_request(fba_pkg::KIND_ALIGN, 10'($urandom), 4'd8);
            issue_request(fba_pkg::KIND_SMALL, 10'($urandom), 4'($urandom_range(1, 4)));
            issue_request(fba_pkg::KIND_ALIGN, 10'($urandom), 4'($urandom_range(1, 4)));
            for (int w = 0; w < MAP_BITS; w += FRAGS)
               issue_request(fba_pkg::KIND_CLEAR, 10'(w + 3), 4'($urandom));
         end else if ($urandom_range(0, 49) == 0) begin
            drain_answers();
         end

         choice = $urandom_range(0, 99);
         hot = $urandom_range(0, MAP_BITS - 64);
         if (choice < 20) begin
            issue_request(fba_pkg::kind_type'($urandom_range(0, 3)), 10'($urandom),
                          4'($urandom));
         end else begin
            if (choice < 30) begin
               // free a whole stretch so long runs show up again
               for (int p = hot; p < hot + 32; p++)
                  issue_request(fba_pkg::KIND_CLEAR, 10'(p), 4'($urandom));
            end else begin
               nops = $urandom_range(1, 6);
               for (int n = 0; n < nops; n++)
                  issue_request($urandom_range(0, 1) ? fba_pkg::KIND_MARK
                                                     : fba_pkg::KIND_CLEAR,
                                10'(hot + $urandom_range(0, 63)), 4'($urandom));
            end
            cnt = ($urandom_range(0, 4) != 0) ? 4'($urandom_range(1, 8))
                                              : 4'($urandom_range(0, 15));
            issue_request(fba_pkg::kind_type'($urandom_range(0, 1)), 10'($urandom), cnt);
         end
      end

      steady = 1'b0;
      drain_answers();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d best-fit and %0d aligned searches (%0d with no place),",
               n_small, n_align, n_no_place);
      $display("%0d marks and %0d clears; %0d result beats checked, %0d mismatches.",
               n_mark, n_clear, n_checked, errors);
      if (errors == 0) begin
         $display("fragment_bitmap_allocator_top test passed");
      end else begin
         $display("fragment_bitmap_allocator_top test failed");
      end
      $finish;
   end

   initial begin
      #150_000_000;
      $display("fragment_bitmap_allocator_top test failed");
      $finish;
   end

endmodule

>>> fragment_bitmap_allocator_top.f
rtl/core/fba_pkg.sv
rtl/core/fba_ram.sv
rtl/core/fragment_bitmap_allocator_top.sv
rtl/core/fba_checker.sv
dv/testbench.sv
